### src/catmull_rom_loop_evaluator_unit_defines.svh
// Assertion macros for the closed-loop Catmull-Rom spline evaluator.
`ifndef CATMULL_ROM_LOOP_EVALUATOR_UNIT_DEFINES_SVH
`define CATMULL_ROM_LOOP_EVALUATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CRLE_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("crle check failed");
`define CRLE_CHECK_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("crle sequence check failed");
`else
`define CRLE_CHECK(lbl, expr)
`define CRLE_CHECK_NEXT(lbl, pre, post)
`endif
`endif

### src/crle_pkg.sv
// Shared types, constants and arithmetic helpers for the spline evaluator.
`default_nettype none
package crle_pkg;
	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int COUNT_W    = 7;
	localparam int COORD_W    = 32;
	localparam int PARAM_W    = 16;
	localparam int ACC_W      = COORD_W + 8;
	localparam int POINT_W    = 3 * COORD_W;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);

	typedef struct packed {
		logic                      operation;
		logic [5:0]                point_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic [PARAM_W-1:0]        loop_param;
	} in_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] tangent_x;
		logic signed [COORD_W-1:0] tangent_y;
		logic signed [COORD_W-1:0] tangent_z;
	} out_rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	// round(h * f / 2^PARAM_W), half away from zero
	function automatic logic signed [ACC_W-1:0] mul_frac(
		input logic signed [ACC_W-1:0] h,
		input logic [PARAM_W-1:0]      f
	);
		logic [ACC_W-1:0]         m;
		logic [ACC_W+PARAM_W-1:0] prod;
		logic [ACC_W-1:0]         r;
		m    = h[ACC_W-1] ? (~h + ACC_W'(1)) : h;
		prod = (ACC_W+PARAM_W)'(m) * (ACC_W+PARAM_W)'(f)
			+ (ACC_W+PARAM_W)'(1 << (PARAM_W - 1));
		r    = prod[ACC_W+PARAM_W-1:PARAM_W];
		return h[ACC_W-1] ? -$signed(r) : $signed(r);
	endfunction

	// halve with rounding away from zero, then clamp to the coordinate range
	function automatic logic [COORD_W-1:0] halve_sat(input logic signed [ACC_W-1:0] h);
		logic [ACC_W-1:0] m;
		logic [ACC_W-1:0] lim;
		m   = ((h[ACC_W-1] ? (~h + ACC_W'(1)) : h) + ACC_W'(1)) >> 1;
		lim = ACC_W'(1) << (COORD_W - 1);
		if (h[ACC_W-1]) begin
			if (m > lim)
				m = lim;
			m = ~m + ACC_W'(1);
		end else if (m > lim - ACC_W'(1)) begin
			m = lim - ACC_W'(1);
		end
		return m[COORD_W-1:0];
	endfunction
endpackage
`default_nettype wire

### src/crle_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module crle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule
`default_nettype wire

### src/crle_axis.sv
// One axis of the basis: coefficient sums, three Horner steps, halve and clamp.
`default_nettype none
module crle_axis (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [crle_pkg::COORD_W-1:0] p0,
	input  wire logic signed [crle_pkg::COORD_W-1:0] p1,
	input  wire logic signed [crle_pkg::COORD_W-1:0] p2,
	input  wire logic signed [crle_pkg::COORD_W-1:0] p3,
	input  wire logic [crle_pkg::PARAM_W-1:0]        frac,
	output logic      [crle_pkg::COORD_W-1:0]        pos,
	output logic      [crle_pkg::COORD_W-1:0]        tangent
);
	import crle_pkg::*;

	logic signed [ACC_W-1:0] e0, e1, e2, e3;
	logic signed [ACC_W-1:0] a0;
	logic signed [ACC_W-1:0] h_s3, g_s3, a1_s3, a2_s3, a3_s3;
	logic signed [ACC_W-1:0] h_s4, g_s4, a2_s4, a3_s4;
	logic signed [ACC_W-1:0] h_s5, g_s5, a3_s5;
	logic signed [ACC_W-1:0] h_s6, g_s6;
	logic [PARAM_W-1:0]      frac_s3, frac_s4, frac_s5;

	assign e0 = ACC_W'(p0);
	assign e1 = ACC_W'(p1);
	assign e2 = ACC_W'(p2);
	assign e3 = ACC_W'(p3);
	assign a0 = -e0 + 3 * e1 - 3 * e2 + e3;

	always_ff @(posedge clk) begin
		if (en) begin
			h_s3    <= a0;
			g_s3    <= 3 * a0;
			a1_s3   <= 2 * e0 - 5 * e1 + 4 * e2 - e3;
			a2_s3   <= e2 - e0;
			a3_s3   <= 2 * e1;
			frac_s3 <= frac;

			h_s4    <= a1_s3 + mul_frac(h_s3, frac_s3);
			g_s4    <= 2 * a1_s3 + mul_frac(g_s3, frac_s3);
			a2_s4   <= a2_s3;
			a3_s4   <= a3_s3;
			frac_s4 <= frac_s3;

			h_s5    <= a2_s4 + mul_frac(h_s4, frac_s4);
			g_s5    <= a2_s4 + mul_frac(g_s4, frac_s4);
			a3_s5   <= a3_s4;
			frac_s5 <= frac_s4;

			h_s6    <= a3_s5 + mul_frac(h_s5, frac_s5);
			g_s6    <= g_s5;

			pos     <= halve_sat(h_s6);
			tangent <= halve_sat(g_s6);
		end
	end
endmodule
`default_nettype wire

### src/catmull_rom_loop_evaluator_unit.sv
// Top level of the closed-loop Catmull-Rom spline evaluator.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------
//  in       | in_valid / in_stall  | in_req  (in_req_t)
//  out      | out_valid / out_stall| out_rsp (out_rsp_t)
//  config   | cfg_we               | cfg_wdata (point count)
//
// One request per cycle while the output is not stalled. An evaluate passes
// through the segment multiply, the point store read, the coefficient sums,
// the three multiply-add steps of each axis and the final halve and clamp.
// Loads write the store and give no result.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears valid bits and sets the point count to 4; the store is not cleared.
`include "catmull_rom_loop_evaluator_unit_defines.svh"
`default_nettype none
module catmull_rom_loop_evaluator_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire crle_pkg::in_req_t                in_req,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output crle_pkg::out_rsp_t                    out_rsp,
	input  wire logic                             cfg_we,
	input  wire logic [crle_pkg::COUNT_W-1:0]     cfg_wdata
);
	import crle_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] n_eff;
	logic               en;
	logic [PARAM_W+COUNT_W-1:0] prod;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic               op_s1;
	logic [IDX_W-1:0]   slot_s1;
	point_t             pt_s1;
	logic [COUNT_W-1:0] seg_s1;
	logic [PARAM_W-1:0] frac_s1, frac_s2;

	logic [COUNT_W-1:0] i0, i2, i3;
	logic               ram_we;
	point_t             rd0, rd1, rd2, rd3;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_comb begin
		n_eff = count_q;
		if (count_q == '0)
			n_eff = COUNT_W'(1);
		else if (count_q > COUNT_W'(MAX_POINTS))
			n_eff = COUNT_W'(MAX_POINTS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= COUNT_RESET;
		else if (cfg_we)
			count_q <= cfg_wdata;
	end

	assign prod = (PARAM_W+COUNT_W)'(in_req.loop_param) * (PARAM_W+COUNT_W)'(n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1 && (op_s1 == OP_EVAL);
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			out_valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= in_req.operation;
			slot_s1 <= in_req.point_index[IDX_W-1:0];
			pt_s1   <= '{x: in_req.point_x, y: in_req.point_y, z: in_req.point_z};
			seg_s1  <= prod[PARAM_W+COUNT_W-1:PARAM_W];
			frac_s1 <= prod[PARAM_W-1:0];
			frac_s2 <= frac_s1;
		end
	end

	// segment is below the count, so only the neighbors need a wrap
	always_comb begin
		i0 = (seg_s1 == '0) ? n_eff - COUNT_W'(1) : seg_s1 - COUNT_W'(1);
		i2 = (seg_s1 + COUNT_W'(1) == n_eff) ? '0 : seg_s1 + COUNT_W'(1);
		i3 = (i2 + COUNT_W'(1) == n_eff) ? '0 : i2 + COUNT_W'(1);
	end

	assign ram_we = en && v_s1 && (op_s1 == OP_LOAD);

	crle_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ram_a (
		.clk(clk), .we(ram_we), .waddr(slot_s1), .wdata(pt_s1), .re(en),
		.raddr_a(i0[IDX_W-1:0]), .raddr_b(seg_s1[IDX_W-1:0]),
		.rdata_a(rd0), .rdata_b(rd1)
	);

	crle_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ram_b (
		.clk(clk), .we(ram_we), .waddr(slot_s1), .wdata(pt_s1), .re(en),
		.raddr_a(i2[IDX_W-1:0]), .raddr_b(i3[IDX_W-1:0]),
		.rdata_a(rd2), .rdata_b(rd3)
	);

	crle_axis u_axis_x (
		.clk(clk), .en(en), .p0(rd0.x), .p1(rd1.x), .p2(rd2.x), .p3(rd3.x),
		.frac(frac_s2), .pos(out_rsp.pos_x), .tangent(out_rsp.tangent_x)
	);

	crle_axis u_axis_y (
		.clk(clk), .en(en), .p0(rd0.y), .p1(rd1.y), .p2(rd2.y), .p3(rd3.y),
		.frac(frac_s2), .pos(out_rsp.pos_y), .tangent(out_rsp.tangent_y)
	);

	crle_axis u_axis_z (
		.clk(clk), .en(en), .p0(rd0.z), .p1(rd1.z), .p2(rd2.z), .p3(rd3.z),
		.frac(frac_s2), .pos(out_rsp.pos_z), .tangent(out_rsp.tangent_z)
	);

	`CRLE_CHECK(a_seg_in_range, !(v_s1 && op_s1 == OP_EVAL) || (seg_s1 < n_eff))
	`CRLE_CHECK_NEXT(a_load_no_result, v_s1 && op_s1 == OP_LOAD && en, !v_s2)
	`CRLE_CHECK_NEXT(a_read_holds, v_s2 && !en, $stable(rd0) && $stable(rd3))
endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for the closed-loop Catmull-Rom spline evaluator.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import crle_pkg::*;

	typedef logic signed [47:0] wide_t;

	class spline_board;
		point_t   points [MAX_POINTS];
		bit       written [MAX_POINTS];
		int       count;
		out_rsp_t pending [$];
		int       errors;

		function new();
			count = 4;
			errors = 0;
			foreach (written[i]) written[i] = 0;
		endfunction

		function wide_t scale_frac(wide_t h, logic [15:0] f);
			logic [47:0] m;
			logic [63:0] p;
			m = h < 0 ? -h : h;
			p = 64'(m) * 64'(f) + 64'(32768);
			m = p[63:16];
			return h < 0 ? -$signed(m) : $signed(m);
		endfunction

		function logic [31:0] halve_clamp(wide_t h);
			logic [47:0] m;
			m = ((h < 0) ? -h : h) + 1;
			m = m >> 1;
			if (h < 0) begin
				if (m > 48'h8000_0000) m = 48'h8000_0000;
				m = -m;
			end else if (m > 48'h7FFF_FFFF) begin
				m = 48'h7FFF_FFFF;
			end
			return m[31:0];
		endfunction

		// true if the segment for this parameter reads only written points
		function bit can_eval(logic [15:0] lp);
			int n, seg;
			n = count == 0 ? 1 : (count > MAX_POINTS ? MAX_POINTS : count);
			seg = (int'(lp) * n) >> 16;
			for (int k = 0; k < 4; k++)
				if (!written[(seg + n - 1 + k) % n]) return 0;
			return 1;
		endfunction

		function void note_request(in_req_t r);
			int n, seg, idx [4];
			logic [31:0] s;
			logic [15:0] f;
			wide_t p [4];
			wide_t a0, a1, a2, a3, h, g;
			out_rsp_t o;
			logic [31:0] pos [3];
			logic [31:0] tan [3];
			if (r.operation == OP_LOAD) begin
				points[r.point_index] = '{r.point_x, r.point_y, r.point_z};
				written[r.point_index] = 1;
				return;
			end
			n = count == 0 ? 1 : (count > MAX_POINTS ? MAX_POINTS : count);
			s = 32'(r.loop_param) * 32'(n);
			seg = int'(s[31:16]);
			f = s[15:0];
			for (int k = 0; k < 4; k++) idx[k] = (seg + n - 1 + k) % n;
			for (int ax = 0; ax < 3; ax++) begin
				for (int k = 0; k < 4; k++)
					p[k] = ax == 0 ? wide_t'(points[idx[k]].x) :
						ax == 1 ? wide_t'(points[idx[k]].y) : wide_t'(points[idx[k]].z);
				a0 = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
				a1 = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
				a2 = p[2] - p[0];
				a3 = 2 * p[1];
				h = a1 + scale_frac(a0, f);
				h = a2 + scale_frac(h, f);
				h = a3 + scale_frac(h, f);
				g = 2 * a1 + scale_frac(3 * a0, f);
				g = a2 + scale_frac(g, f);
				pos[ax] = halve_clamp(h);
				tan[ax] = halve_clamp(g);
			end
			o.pos_x = pos[0]; o.pos_y = pos[1]; o.pos_z = pos[2];
			o.tangent_x = tan[0]; o.tangent_y = tan[1]; o.tangent_z = tan[2];
			pending.push_back(o);
		endfunction

		function void check_result(out_rsp_t got);
			out_rsp_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_req_t in_req = '0;
	logic out_valid;
	logic out_stall = 0;
	out_rsp_t out_rsp;
	logic cfg_we = 0;
	logic [COUNT_W-1:0] cfg_wdata = '0;

	spline_board board = new();
	int idle_pct = 24;
	bit quiet = 0;

	catmull_rom_loop_evaluator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
		.out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// result side: random stall, check accepted results
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(out_rsp);
		out_stall <= !quiet && ($urandom_range(99) < idle_pct);
	end

	task automatic send_request(in_req_t r);
		while (!quiet && $urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_req <= r;
		do @(posedge clk); while (in_stall);
		board.note_request(r);
	endtask

	task automatic set_count(int n);
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= COUNT_W'(n);
		@(posedge clk);
		cfg_we <= 0;
		board.count = n;
	endtask

	task automatic load_point(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_req_t r;
		r = '0;
		r.operation = OP_LOAD;
		r.point_index = 6'(slot);
		r.point_x = x; r.point_y = y; r.point_z = z;
		r.loop_param = 16'($urandom);
		send_request(r);
	endtask

	task automatic evaluate(logic [15:0] lp);
		in_req_t r;
		r.operation = OP_EVAL;
		r.point_index = 6'($urandom);
		r.point_x = $urandom; r.point_y = $urandom; r.point_z = $urandom;
		r.loop_param = lp;
		send_request(r);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(1) ? 32'hFFF0_0000 | $urandom : $urandom_range(32'hFFFFF);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int sent, n;
		logic [15:0] lp;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: reset count of four, extremes, saturation
		load_point(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		load_point(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
		load_point(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		load_point(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
		load_point(63, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		evaluate(16'h0000); evaluate(16'hFFFF); evaluate(16'h8000);
		evaluate(16'h4000); evaluate(16'h2000); evaluate(16'h7FFF);
		set_count(1);
		evaluate(16'h0000); evaluate(16'hFFFF); evaluate(16'h5555);
		set_count(0);
		evaluate(16'hAAAA);
		// count above the store size saturates; fill every slot first
		for (int i = 4; i < 63; i++) load_point(i, rand_coord(), rand_coord(), rand_coord());
		set_count(127);
		evaluate(16'hFFFF); evaluate(16'h0001);
		sent = 0;
		while (sent < 1800) begin
			case ($urandom_range(3))
				0: n = $urandom_range(1, 4);
				1: n = 64;
				2: n = $urandom_range(65, 127);
				default: n = $urandom_range(1, 64);
			endcase
			set_count(n);
			quiet = $urandom_range(4) == 0;
			for (int j = 0; j < 150; j++) begin
				if ($urandom_range(99) < 25) begin
					load_point($urandom_range(63), rand_coord(), rand_coord(), rand_coord());
				end else begin
					lp = $urandom_range(3) == 0 ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
						: 16'($urandom);
					if (board.can_eval(lp)) evaluate(lp);
				end
				sent++;
			end
			quiet = 0;
		end
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
